>>> hdl/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared widths and defaults for the interval partition counter unit.
// ----------------------------------------------------------------------------
package ipc_pkg;

  // Width of a begin or end time in nanoseconds.
  localparam int unsigned TIME_W = 64;

  // Widths of the reported slot index and slot count fields.
  localparam int unsigned SLOT_IDX_W = 6;
  localparam int unsigned SLOT_CNT_W = 7;

  // Default number of slots in the end-time table.
  localparam int unsigned IPC_SLOTS = 64;

endpackage

>>> hdl/ipc_ram.sv
// ----------------------------------------------------------------------------
// ipc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ipc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; the contents have no reset.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/interval_partition_counter_unit.sv
// ----------------------------------------------------------------------------
// interval_partition_counter_unit
// Greedy interval partitioning: each request reuses the open slot with the
// earliest end time if it ends strictly before the request's begin time,
// otherwise opens a new slot or, if none is free, flags overflow; a one-cycle strobe reports the outcome.
// ----------------------------------------------------------------------------
// After the accepting edge the unit scans each open slot in turn, then decides
// and registers the strobe; with no slot open it goes straight to the decide
// state. A new request is taken only once busy has fallen back to idle; the scan
// rate is set by the single end-time RAM read port, one slot per cycle,
// feeding the one shared 64-bit comparator. The receiver cannot stall.
// Reset clears the slot count and the control state; the end-time table is
// not cleared, as only opened slots are ever read.
// ----------------------------------------------------------------------------
module interval_partition_counter_unit #(
  parameter int unsigned SLOTS = ipc_pkg::IPC_SLOTS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [ipc_pkg::TIME_W-1:0]     from_ns_i,
  input  logic [ipc_pkg::TIME_W-1:0]     to_ns_i,
  output logic                           result_valid_o,
  output logic [ipc_pkg::SLOT_IDX_W-1:0] slot_index_o,
  output logic [ipc_pkg::SLOT_CNT_W-1:0] slots_in_use_o,
  output logic                           slot_reused_o,
  output logic                           overflow_o
);

  import ipc_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] SlotsMax = CNT_W'(SLOTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [TIME_W-1:0] best_q;
  logic [TIME_W-1:0] begin_q;
  logic [TIME_W-1:0] end_q;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [TIME_W-1:0] ram_rdata;

  logic [TIME_W-1:0] cmp_a;
  logic [TIME_W-1:0] cmp_b;
  logic              cmp_lt;
  logic [CNT_W-1:0]  next_idx;
  logic              reuse;
  logic              room;

  // End-time table, one entry per slot.
  ipc_ram #(
    .WIDTH(TIME_W),
    .DEPTH(SLOTS)
  ) u_slot_end (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(end_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy = (state_q != ST_IDLE);

  // The one shared comparator: slot against running minimum while scanning,
  // then minimum against the begin time when deciding.
  always_comb begin
    if (state_q == ST_DECIDE) begin
      cmp_a = best_q;
      cmp_b = begin_q;
    end else begin
      cmp_a = ram_rdata;
      cmp_b = best_q;
    end
  end
  assign cmp_lt = (cmp_a < cmp_b);

  assign next_idx = CNT_W'(cmp_idx_q) + CNT_W'(1);
  assign reuse    = (count_q != '0) && cmp_lt;
  assign room     = (count_q < SlotsMax);

  // Read ahead by one slot so that a compare happens in every scan cycle.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state_q)
      ST_IDLE: begin
        ram_re = start && (count_q != '0);
      end
      ST_SCAN: begin
        ram_re    = (next_idx < count_q);
        ram_raddr = IDX_W'(next_idx);
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // The slot write happens in the decide cycle: a reused or a new slot.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx_q;
    if (state_q == ST_DECIDE) begin
      if (reuse) begin
        ram_we = 1'b1;
      end else if (room) begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(count_q);
      end
    end
  end

  // Sequencer with registered results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      count_q        <= '0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            begin_q   <= from_ns_i;
            end_q     <= to_ns_i;
            cmp_idx_q <= '0;
            state_q   <= (count_q != '0) ? ST_SCAN : ST_DECIDE;
          end
        end
        ST_SCAN: begin
          // The first slot seeds the minimum; ties keep the lower index.
          if ((cmp_idx_q == '0) || cmp_lt) begin
            best_q     <= ram_rdata;
            best_idx_q <= cmp_idx_q;
          end
          cmp_idx_q <= IDX_W'(next_idx);
          if (next_idx == count_q) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          result_valid_o <= 1'b1;
          state_q        <= ST_IDLE;
          if (reuse) begin
            slot_index_o   <= SLOT_IDX_W'(best_idx_q);
            slots_in_use_o <= SLOT_CNT_W'(count_q);
            slot_reused_o  <= 1'b1;
            overflow_o     <= 1'b0;
          end else if (room) begin
            slot_index_o   <= SLOT_IDX_W'(count_q);
            slots_in_use_o <= SLOT_CNT_W'(count_q + CNT_W'(1));
            slot_reused_o  <= 1'b0;
            overflow_o     <= 1'b0;
            count_q        <= count_q + CNT_W'(1);
          end else begin
            slot_index_o   <= '0;
            slots_in_use_o <= SLOT_CNT_W'(count_q);
            slot_reused_o  <= 1'b0;
            overflow_o     <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the interval partition counter unit. Interval
// requests are queued up front, driven one at a time by a clocked driver and
// predicted at the accepting edge. A monitor compares every result strobe
// with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  import ipc_pkg::*;

  localparam int unsigned SLOTS       = IPC_SLOTS;
  localparam int unsigned RAND_ITEMS  = 1100;
  localparam int unsigned QUIET_TAIL  = 150;
  localparam int unsigned DRAIN_EVERY = 350;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [TIME_W-1:0] t_begin;
    logic [TIME_W-1:0] t_end;
  } interval_t;

  typedef struct packed {
    logic [SLOT_IDX_W-1:0] slot;
    logic [SLOT_CNT_W-1:0] in_use;
    logic                  reused;
    logic                  ovf;
  } outcome_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [TIME_W-1:0]     from_ns = '0;
  logic [TIME_W-1:0]     to_ns = '0;
  logic                  result_valid;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic [SLOT_CNT_W-1:0] slots_in_use;
  logic                  slot_reused;
  logic                  overflow;

  interval_t         interval_q[$];
  outcome_t          outcome_q[$];
  logic [TIME_W-1:0] end_table[SLOTS];
  int unsigned       open_slots = 0;
  int unsigned       n_total = 0;
  int unsigned       n_issued = 0;
  int unsigned       n_accepted = 0;
  int unsigned       gap_left = 0;
  int unsigned       errors = 0;

  interval_partition_counter_unit #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .from_ns_i      (from_ns),
    .to_ns_i        (to_ns),
    .result_valid_o (result_valid),
    .slot_index_o   (slot_index),
    .slots_in_use_o (slots_in_use),
    .slot_reused_o  (slot_reused),
    .overflow_o     (overflow)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Greedy slot choice: the lowest-indexed slot with the earliest end time is
  // reused if it ends strictly before the request begins, else a slot opens.
  function automatic outcome_t allot_slot(input logic [TIME_W-1:0] t_begin,
                                          input logic [TIME_W-1:0] t_end);
    outcome_t          res;
    logic [TIME_W-1:0] least;
    int unsigned       least_idx;
    res       = '0;
    least     = '1;
    least_idx = 0;
    for (int unsigned i = 0; i < open_slots; i++) begin
      if (i == 0 || end_table[i] < least) begin
        least     = end_table[i];
        least_idx = i;
      end
    end
    if (open_slots != 0 && least < t_begin) begin
      end_table[least_idx] = t_end;
      res.slot             = least_idx[SLOT_IDX_W-1:0];
      res.reused           = 1'b1;
    end else if (open_slots < SLOTS) begin
      end_table[open_slots] = t_end;
      res.slot              = open_slots[SLOT_IDX_W-1:0];
      open_slots++;
    end else begin
      res.ovf = 1'b1;
    end
    res.in_use = open_slots[SLOT_CNT_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [SLOT_CNT_W-1:0] want,
                             input logic [SLOT_CNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Result check first, then prediction of any request taken at this edge.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (result_valid) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual slot %0d",
                   $time, slot_index);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          check_field("slot_index", SLOT_CNT_W'(want.slot), SLOT_CNT_W'(slot_index));
          check_field("slots_in_use", want.in_use, slots_in_use);
          check_field("slot_reused", SLOT_CNT_W'(want.reused), SLOT_CNT_W'(slot_reused));
          check_field("overflow", SLOT_CNT_W'(want.ovf), SLOT_CNT_W'(overflow));
        end
      end
      if (start && !busy) begin
        outcome_q.push_back(allot_slot(from_ns, to_ns));
        n_accepted++;
      end
    end
  end

  // Request driver: holds each request until taken, then idles in random
  // bursts, and now and then waits for every outstanding result to arrive.
  always @(negedge clk_i) begin
    interval_t item;
    logic      start_nxt;
    logic      draining;
    start_nxt = start;
    if (rst_ni && (!start || n_accepted == n_issued)) begin
      start_nxt = 1'b0;
      draining  = (n_issued != 0) && (n_issued % DRAIN_EVERY == 0) &&
                  (outcome_q.size() != 0);
      if (gap_left != 0) begin
        gap_left--;
      end else if (interval_q.size() != 0 && !draining) begin
        item      = interval_q.pop_front();
        from_ns   <= item.t_begin;
        to_ns     <= item.t_end;
        start_nxt = 1'b1;
        n_issued++;
        if (n_issued + QUIET_TAIL < n_total && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 8);
        end
      end
    end
    start <= start_nxt;
  end

  // Watchdog.
  initial begin
    for (int unsigned cyc = 0; cyc < CYCLE_LIMIT; cyc++) begin
      @(posedge clk_i);
    end
    $display("tb NOT OK");
    $finish;
  end

  // Stimulus generation, reset and end of run.
  initial begin
    interval_t         it;
    interval_t         prev;
    logic [TIME_W-1:0] base;
    int unsigned       span;
    int unsigned       roll;

    // Directed requests: empty table, equal times, ties, end before begin and
    // the extremes of both time fields.
    interval_q.push_back('{64'd0, 64'd0});
    interval_q.push_back('{64'd0, 64'd5});
    interval_q.push_back('{64'd0, 64'd5});
    interval_q.push_back('{64'd1, 64'd5});
    interval_q.push_back('{64'd6, 64'd3});
    interval_q.push_back('{64'd4, 64'd10});
    interval_q.push_back('{64'd6, 64'd7});
    interval_q.push_back('{'1, '1});
    interval_q.push_back('{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555});
    interval_q.push_back('{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA});
    interval_q.push_back('{64'd20, 64'd30});
    interval_q.push_back('{64'd0, 64'd0});
    interval_q.push_back('{64'd31, 64'd40});
    interval_q.push_back('{64'd40, 64'd41});
    interval_q.push_back('{64'd40, 64'd41});

    // Random requests around a slowly advancing time base. The span of each
    // phase sets how many intervals overlap: the long phase fills the table.
    base = 64'd100;
    prev = '{64'd100, 64'd110};
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      if (n < 300)      span = 60;
      else if (n < 600) span = 400;
      else if (n < 850) span = 3000;
      else              span = 80;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        it.t_begin = base + TIME_W'($urandom_range(0, 15));
        it.t_end   = it.t_begin + TIME_W'($urandom_range(0, span));
      end else if (roll < 80) begin
        it.t_begin = prev.t_end;
        it.t_end   = it.t_begin + TIME_W'($urandom_range(1, span));
      end else if (roll < 88) begin
        it.t_begin = base + TIME_W'($urandom_range(0, 15));
        it.t_end   = it.t_begin - TIME_W'($urandom_range(1, 50));
      end else if (roll < 96) begin
        it.t_begin = {$urandom, $urandom};
        it.t_end   = base + TIME_W'($urandom_range(0, span));
      end else begin
        it = prev;
      end
      interval_q.push_back(it);
      prev = it;
      base = base + TIME_W'($urandom_range(0, 8));
    end
    n_total = interval_q.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (interval_q.size() != 0 || n_accepted != n_issued) @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 8) @(posedge clk_i);

    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
